FILE: sv/ngx_pkg.sv
// Package for the noise gate with hold and expansion.
// Holds shared widths, gain constants, enums, structs and the exp2 factor table.
// No dependencies.
`default_nettype none
package ngx_pkg;

  localparam int GAIN_W  = 16;
  localparam int CFG_W   = 23;
  localparam int HOLD_W  = 19;
  localparam int LEVEL_W = 23;
  localparam int MUL_W   = 64;
  localparam int MULB_W  = 32;
  localparam int NB_W    = 6;
  localparam int FAC_W   = 31;
  localparam int FAC_MAX = 12;
  localparam int FI_W    = 4;

  localparam logic [GAIN_W-1:0] UNITY        = 16'd32768;
  localparam logic [GAIN_W-1:0] OPEN_MARK    = 16'd32440;
  localparam logic [GAIN_W-1:0] CLOSE_MARGIN = 16'd33;

  typedef enum logic [2:0] {
    PH_CLOSED  = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_OPEN    = 3'd2,
    PH_HOLD    = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    CFG_ENABLE    = 3'd0,
    CFG_THRESHOLD = 3'd1,
    CFG_CLOSED    = 3'd2,
    CFG_ATTACK    = 3'd3,
    CFG_RELEASE   = 3'd4,
    CFG_HOLD      = 3'd5,
    CFG_INV_RATIO = 3'd6,
    CFG_EXPAND    = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SM1,
    S_SM2,
    S_NORM,
    S_SQ,
    S_LM,
    S_EXP,
    S_SCL,
    S_SCR,
    S_DONE
  } seq_t;

  typedef struct packed {
    logic [2:0]        phase;
    logic [GAIN_W-1:0] sgain;
    logic [HOLD_W-1:0] hold;
    logic              above;
    logic [GAIN_W-1:0] cg;
    logic [HOLD_W-1:0] hold_samples;
  } phase_in_t;

  typedef struct packed {
    phase_t            phase;
    logic [GAIN_W-1:0] sgain;
    logic [HOLD_W-1:0] hold;
    logic [GAIN_W-1:0] target;
  } phase_out_t;

  typedef logic [FAC_MAX:1][FAC_W-1:0] fac_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic fac_tab_t build_fac();
    fac_tab_t t;
    t[1] = FAC_W'(isqrt64(64'd1 << 59));
    for (int i = 2; i <= FAC_MAX; i++) begin
      t[i] = FAC_W'(isqrt64(64'(t[i-1]) << 30));
    end
    return t;
  endfunction

  localparam fac_tab_t FAC_TAB = build_fac();

endpackage
`default_nettype wire

FILE: sv/ngx_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on ngx_pkg.
`default_nettype none
module ngx_mul
  import ngx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [MUL_W-1:0]  a,
  input  wire logic [MULB_W-1:0] b,
  input  wire logic [NB_W-1:0]   nb,
  output logic                   done,
  output logic [MUL_W-1:0]       prod
);

  logic              busy;
  logic [NB_W-1:0]   cnt;
  logic [MUL_W-1:0]  a_sh;
  logic [MULB_W-1:0] b_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= nb;
        prod <= '0;
        a_sh <= a;
        b_sh <= b;
      end else if (busy) begin
        if (b_sh[0]) prod <= prod + a_sh;
        a_sh <= a_sh << 1;
        b_sh <= b_sh >> 1;
        cnt  <= cnt - 1'b1;
        if (cnt == NB_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/ngx_phase.sv
// Five-phase gate transition logic: next phase, smoothed gain, hold count and target gain.
// Depends on ngx_pkg.
`default_nettype none
module ngx_phase
  import ngx_pkg::*;
(
  input  wire phase_in_t pi,
  output phase_out_t     po
);

  logic [GAIN_W:0] rel_lim;

  always_comb begin
    rel_lim   = {1'b0, pi.cg} + {1'b0, CLOSE_MARGIN};
    po.phase  = PH_CLOSED;
    po.sgain  = pi.sgain;
    po.hold   = pi.hold;
    po.target = pi.cg;
    case (pi.phase)
      PH_ATTACK: begin
        po.target = UNITY;
        po.phase  = PH_ATTACK;
        if (pi.sgain >= OPEN_MARK) begin
          po.phase = PH_OPEN;
          po.sgain = UNITY;
        end
        if (!pi.above) begin
          po.phase = PH_HOLD;
          po.hold  = pi.hold_samples;
        end
      end
      PH_OPEN: begin
        po.target = UNITY;
        po.phase  = PH_OPEN;
        if (!pi.above) begin
          po.phase = PH_HOLD;
          po.hold  = pi.hold_samples;
        end
      end
      PH_HOLD: begin
        po.target = UNITY;
        po.phase  = PH_HOLD;
        if (pi.above) begin
          po.phase = PH_OPEN;
        end else begin
          if (pi.hold <= HOLD_W'(1)) po.phase = PH_RELEASE;
          if (pi.hold != '0) po.hold = pi.hold - 1'b1;
        end
      end
      PH_RELEASE: begin
        po.phase = PH_RELEASE;
        if (pi.above) begin
          po.phase = PH_ATTACK;
        end else if ({1'b0, pi.sgain} <= rel_lim) begin
          po.phase = PH_CLOSED;
          po.sgain = pi.cg;
        end
      end
      default: begin
        po.phase = pi.above ? PH_ATTACK : PH_CLOSED;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/noise_gate_hold_expander.sv
// Stereo noise gate with hold phase, one-pole gain smoothing and an optional
// expansion curve. With the gate enabled, the one bit-serial multiplier carries
// every product of an item in turn. Depends on ngx_pkg, ngx_mul, ngx_phase.
`default_nettype none
module noise_gate_hold_expander
  import ngx_pkg::*;
#(
  parameter int SAMPLE_BITS    = 24,
  parameter int LOG_TABLE_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [CFG_W-1:0]              cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [LEVEL_W-1:0]            detected_level,
  input  wire logic signed [SAMPLE_BITS-1:0] left_in,
  input  wire logic signed [SAMPLE_BITS-1:0] right_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0]      left_out,
  output logic signed [SAMPLE_BITS-1:0]      right_out,
  output logic [GAIN_W-1:0]                  final_gain,
  output logic [2:0]                         gate_phase
);

  localparam int L     = LOG_TABLE_BITS;
  localparam int SB    = SAMPLE_BITS;
  localparam int VW    = L + 4;
  localparam int VI_W  = $clog2(VW);
  localparam int EB_W  = $clog2(L + 1);
  localparam int SQ_W  = $clog2(L);
  localparam logic signed [MUL_W-1:0] SMAX = (MUL_W'(1) << (SB - 1)) - MUL_W'(1);
  localparam logic signed [MUL_W-1:0] SMIN = -SMAX - MUL_W'(1);

  logic                     gate_enable;
  logic [LEVEL_W-1:0]       threshold_level;
  logic [GAIN_W-1:0]        closed_gain;
  logic [14:0]              attack_coef;
  logic [14:0]              release_coef;
  logic [HOLD_W-1:0]        hold_samples;
  logic [GAIN_W-1:0]        inv_ratio;
  logic                     expand_on;

  seq_t                     state, state_next;
  phase_t                   phase_reg, phase_reg_next;
  logic [GAIN_W-1:0]        smoothed_gain, smoothed_gain_next;
  logic [HOLD_W-1:0]        hold_left, hold_left_next;
  logic                     issued, issued_next;
  logic signed [SB-1:0]     xl, xl_next, xr, xr_next;
  logic [14:0]              coef, coef_next;
  logic [GAIN_W-1:0]        tgt, tgt_next;
  logic [31:0]              sacc, sacc_next;
  logic [GAIN_W-1:0]        m, m_next;
  logic [3:0]               lz, lz_next;
  logic [L-1:0]             frac, frac_next;
  logic [SQ_W-1:0]          cnt, cnt_next;
  logic [VW-1:0]            v, v_next;
  logic [FAC_W-1:0]         val, val_next;
  logic [EB_W-1:0]          ebit, ebit_next;
  logic [GAIN_W-1:0]        fg, fg_next;
  logic signed [SB-1:0]     res_l, res_l_next, res_r, res_r_next;

  logic                     mul_start;
  logic [MUL_W-1:0]         mul_a;
  logic [MULB_W-1:0]        mul_b;
  logic [NB_W-1:0]          mul_nb;
  logic                     mul_done;
  logic [MUL_W-1:0]         mul_prod;

  phase_in_t                pin;
  phase_out_t               pout;

  logic [GAIN_W-1:0]        cg, ir;
  logic [31:0]              sum;
  logic [16:0]              gq;
  logic [GAIN_W-1:0]        g16;
  logic [16:0]              m2;
  logic [VW-1:0]            logv;
  logic [VI_W-1:0]          vi;
  logic [FI_W-1:0]          fidx;
  logic [3:0]               q;
  logic [4:0]               shamt;
  logic [31:0]              rnd;
  logic [GAIN_W-1:0]        e16;
  logic signed [MUL_W-1:0]  scl;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_enable     <= 1'b0;
      threshold_level <= '0;
      closed_gain     <= '0;
      attack_coef     <= '0;
      release_coef    <= '0;
      hold_samples    <= '0;
      inv_ratio       <= UNITY;
      expand_on       <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ENABLE:    gate_enable     <= cfg_data[0];
        CFG_THRESHOLD: threshold_level <= cfg_data[LEVEL_W-1:0];
        CFG_CLOSED:    closed_gain     <= cfg_data[GAIN_W-1:0];
        CFG_ATTACK:    attack_coef     <= cfg_data[14:0];
        CFG_RELEASE:   release_coef    <= cfg_data[14:0];
        CFG_HOLD:      hold_samples    <= cfg_data[HOLD_W-1:0];
        CFG_INV_RATIO: inv_ratio       <= cfg_data[GAIN_W-1:0];
        CFG_EXPAND:    expand_on       <= cfg_data[0];
        default:       gate_enable     <= gate_enable;
      endcase
    end
  end

  ngx_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .nb    (mul_nb),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign cg = (closed_gain > UNITY) ? UNITY : closed_gain;
  assign ir = (inv_ratio > UNITY) ? UNITY : inv_ratio;

  always_comb begin
    pin.phase        = phase_reg;
    pin.sgain        = smoothed_gain;
    pin.hold         = hold_left;
    pin.above        = detected_level > threshold_level;
    pin.cg           = cg;
    pin.hold_samples = hold_samples;
  end

  ngx_phase u_phase (
    .pi (pin),
    .po (pout)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase_reg     <= PH_CLOSED;
      smoothed_gain <= '0;
      hold_left     <= '0;
      issued        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      phase_reg     <= phase_reg_next;
      smoothed_gain <= smoothed_gain_next;
      hold_left     <= hold_left_next;
      issued        <= issued_next;
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid  <= 1'b1;
        left_out   <= res_l;
        right_out  <= res_r;
        final_gain <= fg;
        gate_phase <= phase_reg;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    xl    <= xl_next;
    xr    <= xr_next;
    coef  <= coef_next;
    tgt   <= tgt_next;
    sacc  <= sacc_next;
    m     <= m_next;
    lz    <= lz_next;
    frac  <= frac_next;
    cnt   <= cnt_next;
    v     <= v_next;
    val   <= val_next;
    ebit  <= ebit_next;
    fg    <= fg_next;
    res_l <= res_l_next;
    res_r <= res_r_next;
  end

  always_comb begin
    state_next         = state;
    phase_reg_next     = phase_reg;
    smoothed_gain_next = smoothed_gain;
    hold_left_next     = hold_left;
    issued_next        = issued;
    xl_next            = xl;
    xr_next            = xr;
    coef_next          = coef;
    tgt_next           = tgt;
    sacc_next          = sacc;
    m_next             = m;
    lz_next            = lz;
    frac_next          = frac;
    cnt_next           = cnt;
    v_next             = v;
    val_next           = val;
    ebit_next          = ebit;
    fg_next            = fg;
    res_l_next         = res_l;
    res_r_next         = res_r;
    mul_start          = 1'b0;
    mul_a              = '0;
    mul_b              = '0;
    mul_nb             = NB_W'(GAIN_W);

    sum   = sacc + mul_prod[31:0] + 32'd16384;
    gq    = sum[31:15];
    g16   = (gq > {1'b0, UNITY}) ? UNITY : gq[GAIN_W-1:0];
    m2    = mul_prod[31:15];
    logv  = {lz, {L{1'b0}}} - VW'(frac);
    vi    = VI_W'(ebit) - VI_W'(1);
    fidx  = FI_W'(L + 1) - FI_W'(ebit);
    q     = v[VW-1:L];
    shamt = 5'd15 + 5'(q);
    rnd   = 32'(val) + (32'd1 << (shamt - 5'd1));
    e16   = 16'(rnd >> shamt);
    scl   = signed'(mul_prod + MUL_W'(16384)) >>> 15;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          xl_next = left_in;
          xr_next = right_in;
          if (!gate_enable) begin
            phase_reg_next     = PH_CLOSED;
            smoothed_gain_next = '0;
            hold_left_next     = '0;
            res_l_next         = left_in;
            res_r_next         = right_in;
            fg_next            = UNITY;
            state_next         = S_DONE;
          end else begin
            phase_reg_next     = pout.phase;
            smoothed_gain_next = pout.sgain;
            hold_left_next     = pout.hold;
            tgt_next           = pout.target;
            coef_next          = (pout.target > pout.sgain) ? attack_coef : release_coef;
            state_next         = S_SM1;
          end
        end
      end
      S_SM1: begin
        mul_a       = MUL_W'(smoothed_gain);
        mul_b       = MULB_W'(coef);
        mul_start   = !issued;
        issued_next = 1'b1;
        if (mul_done) begin
          issued_next = 1'b0;
          sacc_next   = mul_prod[31:0];
          state_next  = S_SM2;
        end
      end
      S_SM2: begin
        mul_a       = MUL_W'(tgt);
        mul_b       = MULB_W'(UNITY - GAIN_W'(coef));
        mul_start   = !issued;
        issued_next = 1'b1;
        if (mul_done) begin
          issued_next        = 1'b0;
          smoothed_gain_next = g16;
          fg_next            = g16;
          state_next         = S_SCL;
          if (expand_on && g16 < UNITY) begin
            if (g16 == '0) begin
              fg_next = cg;
            end else begin
              m_next     = g16;
              lz_next    = '0;
              state_next = S_NORM;
            end
          end
        end
      end
      S_NORM: begin
        if (m[GAIN_W-1]) begin
          cnt_next   = '0;
          frac_next  = '0;
          state_next = S_SQ;
        end else begin
          m_next  = m << 1;
          lz_next = lz + 4'd1;
        end
      end
      S_SQ: begin
        mul_a       = MUL_W'(m);
        mul_b       = MULB_W'(m);
        mul_start   = !issued;
        issued_next = 1'b1;
        if (mul_done) begin
          issued_next = 1'b0;
          frac_next   = {frac[L-2:0], m2[16]};
          m_next      = m2[16] ? m2[16:1] : m2[15:0];
          cnt_next    = cnt + 1'b1;
          if (cnt == SQ_W'(L - 1)) state_next = S_LM;
        end
      end
      S_LM: begin
        mul_a       = MUL_W'(logv);
        mul_b       = MULB_W'(ir);
        mul_start   = !issued;
        issued_next = 1'b1;
        if (mul_done) begin
          issued_next = 1'b0;
          v_next      = VW'((mul_prod + MUL_W'(16384)) >> 15);
          val_next    = FAC_W'(1) << 30;
          ebit_next   = EB_W'(L);
          state_next  = S_EXP;
        end
      end
      S_EXP: begin
        mul_a  = MUL_W'(val);
        mul_b  = MULB_W'(FAC_TAB[fidx]);
        mul_nb = NB_W'(FAC_W);
        if (ebit == '0) begin
          fg_next    = (e16 > cg) ? e16 : cg;
          state_next = S_SCL;
        end else if (!v[vi]) begin
          ebit_next = ebit - 1'b1;
        end else begin
          mul_start   = !issued;
          issued_next = 1'b1;
          if (mul_done) begin
            issued_next = 1'b0;
            val_next    = FAC_W'((mul_prod + (MUL_W'(1) << 29)) >> 30);
            ebit_next   = ebit - 1'b1;
          end
        end
      end
      S_SCL: begin
        mul_a       = MUL_W'(xl);
        mul_b       = MULB_W'(fg);
        mul_start   = !issued;
        issued_next = 1'b1;
        if (mul_done) begin
          issued_next = 1'b0;
          res_l_next  = (scl > SMAX) ? SB'(SMAX) : (scl < SMIN) ? SB'(SMIN) : SB'(scl);
          state_next  = S_SCR;
        end
      end
      S_SCR: begin
        mul_a       = MUL_W'(xr);
        mul_b       = MULB_W'(fg);
        mul_start   = !issued;
        issued_next = 1'b1;
        if (mul_done) begin
          issued_next = 1'b0;
          res_r_next  = (scl > SMAX) ? SB'(SMAX) : (scl < SMIN) ? SB'(SMIN) : SB'(scl);
          state_next  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/ngx_checker.sv
// Port-level checks for noise_gate_hold_expander, with the bind that attaches them.
// Depends on noise_gate_hold_expander.
`default_nettype none
module ngx_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [SAMPLE_BITS-1:0] left_out,
  input wire logic [15:0]            final_gain,
  input wire logic [2:0]             gate_phase
);

  // One word is in flight at a time, so input is refused right after acceptance.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word was in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(final_gain))
    else $error("stalled output word changed");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> final_gain <= 16'd32768)
    else $error("final gain above unity");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> gate_phase <= 3'd4)
    else $error("gate phase code out of range");

endmodule

bind noise_gate_hold_expander ngx_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_ngx_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .left_out   (left_out),
  .final_gain (final_gain),
  .gate_phase (gate_phase)
);
`default_nettype wire

FILE: tb/sv/testbench.sv
// Testbench for noise_gate_hold_expander: drives stereo words with levels, predicts
// gate phase, smoothed gain, expansion and scaled samples, and checks every result.
// Depends on ngx_pkg and the RTL of the block.
`default_nettype none
module testbench;
  import ngx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = 3'd0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [LEVEL_W-1:0] detected_level = '0;
  logic signed [23:0] left_in = '0;
  logic signed [23:0] right_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [23:0] left_out;
  logic signed [23:0] right_out;
  logic [GAIN_W-1:0] final_gain;
  logic [2:0] gate_phase;

  typedef struct {
    logic [23:0] left;
    logic [23:0] right;
    logic [15:0] gain;
    logic [2:0] phase;
  } gated_word_t;

  gated_word_t expected_words[$];
  int errors = 0;
  int stall_hold = 0;
  bit stall_random = 1'b1;

  logic [31:0] m_enable, m_threshold, m_closed, m_attack, m_release, m_hold_samples;
  logic [31:0] m_inv_ratio, m_expand;
  phase_t m_phase;
  logic [31:0] m_gain, m_hold_left;
  logic [63:0] exp_factor[1:8];

  noise_gate_hold_expander uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("FAIL noise_gate_hold_expander");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
    logic [63:0] v, r, b;
    v = v_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] neg_log2(input logic [31:0] g);
    int p;
    logic [63:0] m, frac;
    p = 0;
    frac = 0;
    for (int i = 0; i < 15; i++) if (g[i]) p = i;
    m = 64'(g) << (15 - p);
    for (int i = 0; i < 8; i++) begin
      m = (m * m) >> 15;
      frac = frac << 1;
      if (m >= 65536) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(15 - p) << 8) - frac;
  endfunction

  function automatic logic [31:0] pow2_neg(input logic [63:0] v);
    logic [63:0] val, q;
    int shift;
    val = 64'd1 << 30;
    q = v >> 8;
    for (int i = 8; i > 0; i--)
      if (v[i-1]) val = (val * exp_factor[8 - (i - 1)] + (64'd1 << 29)) >> 30;
    if (q > 15) return 0;
    shift = 15 + int'(q);
    return 32'((val + (64'd1 << (shift - 1))) >> shift);
  endfunction

  function automatic logic [23:0] scale_sample(input logic signed [23:0] x,
                                               input logic [31:0] g);
    longint p, r;
    p = longint'(x) * longint'(g);
    r = (p + 16384) >>> 15;
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return 24'(r);
  endfunction

  function automatic gated_word_t gate_sample(input logic [22:0] level,
                                              input logic signed [23:0] l,
                                              input logic signed [23:0] r);
    gated_word_t w;
    logic [31:0] cg, ir, target, c, fg, e;
    logic [63:0] g;
    bit above;
    if (!m_enable[0]) begin
      m_phase = PH_CLOSED;
      m_gain = 0;
      m_hold_left = 0;
      w.left = l;
      w.right = r;
      w.gain = UNITY;
      w.phase = PH_CLOSED;
      return w;
    end
    cg = (m_closed > 32768) ? 32768 : m_closed;
    ir = (m_inv_ratio > 32768) ? 32768 : m_inv_ratio;
    above = level > m_threshold;
    target = cg;
    case (m_phase)
      PH_ATTACK: begin
        target = 32768;
        if (m_gain >= 32440) begin
          m_phase = PH_OPEN;
          m_gain = 32768;
        end
        if (!above) begin
          m_phase = PH_HOLD;
          m_hold_left = m_hold_samples;
        end
      end
      PH_OPEN: begin
        target = 32768;
        if (!above) begin
          m_phase = PH_HOLD;
          m_hold_left = m_hold_samples;
        end
      end
      PH_HOLD: begin
        target = 32768;
        if (above) begin
          m_phase = PH_OPEN;
        end else begin
          if (m_hold_left <= 1) m_phase = PH_RELEASE;
          if (m_hold_left > 0) m_hold_left = m_hold_left - 1;
        end
      end
      PH_RELEASE: begin
        if (above) begin
          m_phase = PH_ATTACK;
        end else if (m_gain <= cg + 33) begin
          m_phase = PH_CLOSED;
          m_gain = cg;
        end
      end
      default: begin
        m_phase = above ? PH_ATTACK : PH_CLOSED;
      end
    endcase
    c = (target > m_gain) ? m_attack : m_release;
    g = (64'(c) * m_gain + 64'(32768 - c) * target + 16384) >> 15;
    if (g > 32768) g = 32768;
    m_gain = 32'(g);
    fg = m_gain;
    if (m_expand[0] && m_gain < 32768) begin
      e = 0;
      if (m_gain > 0) e = pow2_neg((neg_log2(m_gain) * ir + 16384) >> 15);
      fg = (e > cg) ? e : cg;
    end
    w.left = scale_sample(l, fg);
    w.right = scale_sample(r, fg);
    w.gain = fg[15:0];
    w.phase = m_phase;
    return w;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ENABLE: m_enable = value & 32'h1;
      CFG_THRESHOLD: m_threshold = value & 32'h7FFFFF;
      CFG_CLOSED: m_closed = value & 32'hFFFF;
      CFG_ATTACK: m_attack = value & 32'h7FFF;
      CFG_RELEASE: m_release = value & 32'h7FFF;
      CFG_HOLD: m_hold_samples = value & 32'h7FFFF;
      CFG_INV_RATIO: m_inv_ratio = value & 32'hFFFF;
      default: m_expand = value & 32'h1;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_word(input logic [22:0] level, input logic [23:0] l,
                           input logic [23:0] r);
    @(negedge clk);
    in_valid <= 1'b1;
    detected_level <= level;
    left_in <= l;
    right_in <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_words.push_back(gate_sample(level, l, r));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] en, input logic [31:0] thr,
                           input logic [31:0] cg, input logic [31:0] atk,
                           input logic [31:0] rel, input logic [31:0] hold,
                           input logic [31:0] ir, input logic [31:0] ex);
    drain();
    write_reg(CFG_ENABLE, en);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_CLOSED, cg);
    write_reg(CFG_ATTACK, atk);
    write_reg(CFG_RELEASE, rel);
    write_reg(CFG_HOLD, hold);
    write_reg(CFG_INV_RATIO, ir);
    write_reg(CFG_EXPAND, ex);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      default: return 24'($urandom);
    endcase
  endfunction

  // Levels cluster around the threshold in runs, so the gate cycles through every phase.
  task automatic random_burst(input int count, input logic [31:0] thr);
    int run;
    bit loud;
    run = 0;
    loud = 1'b0;
    for (int i = 0; i < count; i++) begin
      logic [22:0] level;
      if (run == 0) begin
        run = $urandom_range(1, 12);
        loud = $urandom_range(0, 1);
      end
      run--;
      if ($urandom_range(0, 9) == 0) level = 23'($urandom);
      else if (loud) level = (thr >= 32'h7FFFFF) ? 23'h7FFFFF : 23'(thr + 1 + $urandom_range(0, 99));
      else level = 23'(thr - ((thr > 100) ? $urandom_range(0, 100) : thr));
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 20)) @(negedge clk);
      send_word(level, rand_sample(), rand_sample());
    end
  endtask

  task automatic test_passthrough();
    configure(0, 0, 0, 0, 0, 0, 32768, 0);
    send_word(23'h7FFFFF, 24'h7FFFFF, 24'h800000);
    send_word(0, 24'h800000, 24'h7FFFFF);
    send_word(5, 24'h000001, 24'hFFFFFF);
  endtask

  task automatic test_phases();
    configure(1, 1000, 4000, 16000, 20000, 0, 32768, 0);
    send_word(0, 24'h7FFFFF, 24'h800000);
    for (int i = 0; i < 6; i++) send_word(2000, 24'h400000, 24'hC00000);
    for (int i = 0; i < 6; i++) send_word(1000, 24'h7FFFFF, 24'h800000);
    send_word(23'h7FFFFF, 24'h123456, 24'hABCDEF);
    for (int i = 0; i < 8; i++) send_word(0, 24'h7FFFFF, 24'h800000);
  endtask

  task automatic test_extremes();
    configure(1, 0, 65535, 32767, 0, 3, 65535, 1);
    random_burst(30, 0);
    configure(1, 32'h7FFFFF, 0, 0, 32767, 32'h7FFFF, 0, 1);
    random_burst(15, 32'h7FFFFF);
  endtask

  task automatic test_expansion();
    configure(1, 5000, 100, 30000, 31000, 4, 16384, 1);
    random_burst(80, 5000);
    configure(1, 200000, 0, 20000, 32000, 0, 8000, 1);
    random_burst(80, 200000);
  endtask

  task automatic test_back_pressure();
    configure(1, 3000, 2000, 24000, 28000, 2, 32768, 0);
    stall_hold = 300;
    random_burst(20, 3000);
  endtask

  task automatic test_random_settings();
    for (int k = 0; k < 8; k++) begin
      logic [31:0] thr;
      thr = $urandom_range(0, 8388607);
      configure(($urandom_range(0, 7) != 0), thr, $urandom_range(0, 32768),
                $urandom_range(0, 32767), $urandom_range(0, 32767),
                $urandom_range(0, 6), $urandom_range(0, 32768), $urandom_range(0, 1));
      random_burst(40, thr);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: left_out %0d", left_out);
        errors++;
      end else begin
        gated_word_t w;
        w = expected_words.pop_front();
        if (left_out !== w.left) begin
          $error("left_out expected %0d actual %0d", $signed(w.left), left_out);
          errors++;
        end
        if (right_out !== w.right) begin
          $error("right_out expected %0d actual %0d", $signed(w.right), right_out);
          errors++;
        end
        if (final_gain !== w.gain) begin
          $error("final_gain expected %0d actual %0d", w.gain, final_gain);
          errors++;
        end
        if (gate_phase !== w.phase) begin
          $error("gate_phase expected %0d actual %0d", w.phase, gate_phase);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_hold > 0) begin
      out_ready <= 1'b0;
      stall_hold <= stall_hold - 1;
    end else if (stall_random) begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    exp_factor[1] = int_sqrt(64'd1 << 59);
    for (int i = 2; i <= 8; i++) exp_factor[i] = int_sqrt(exp_factor[i-1] << 30);
    m_enable = 0;
    m_threshold = 0;
    m_closed = 0;
    m_attack = 0;
    m_release = 0;
    m_hold_samples = 0;
    m_inv_ratio = 32768;
    m_expand = 0;
    m_phase = PH_CLOSED;
    m_gain = 0;
    m_hold_left = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_passthrough();
    test_phases();
    test_extremes();
    stall_random = 1'b0;
    test_expansion();
    stall_random = 1'b1;
    test_back_pressure();
    test_random_settings();
    drain();
    if (errors == 0) begin
      $display("PASS noise_gate_hold_expander");
    end else begin
      $display("FAIL noise_gate_hold_expander");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
sv/ngx_pkg.sv
sv/ngx_mul.sv
sv/ngx_phase.sv
sv/noise_gate_hold_expander.sv
sv/ngx_checker.sv
tb/sv/testbench.sv
